// ----- src/mbde_pkg.sv -----
// Shared types and constants for the Mandelbox distance estimator.
package mbde_pkg;

    localparam int FRAC     = 16;
    localparam int IN_W     = 20;
    localparam int Z_W      = FRAC + 10;
    localparam int DR_W     = 32 + FRAC;
    localparam int MAXIT_W  = 5;
    localparam int SCALE_W  = 19;
    localparam int MINR_W   = 17;
    localparam int FIXR_W   = 18;
    localparam int DIST_W   = 22;
    localparam int CFG_W    = 22;
    localparam int CFG_AW   = 3;
    localparam int F_W      = FIXR_W + FRAC + 1;
    localparam int MUL_A_W  = DR_W;
    localparam int MUL_DIG  = 12;
    localparam int MUL_NDIG = (F_W + MUL_DIG - 1) / MUL_DIG;
    localparam int MUL_B_W  = MUL_NDIG * MUL_DIG;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int RND_W    = MUL_P_W - FRAC + 1;
    localparam int R2_W     = 2 * Z_W + 2;
    localparam int SQ_W     = R2_W / 2;
    localparam int DIV_W    = DR_W;

    localparam logic [DR_W-1:0]   ONE_Q    = DR_W'(64'd1 << FRAC);
    localparam logic [DR_W-1:0]   DR_MAX   = '1;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic [R2_W-1:0]   ESC_R2   = R2_W'(64'd100 << (2 * FRAC));

    localparam logic [CFG_AW-1:0] CFG_MAX_IT    = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] CFG_SCALE     = CFG_AW'(1);
    localparam logic [CFG_AW-1:0] CFG_MIN_R     = CFG_AW'(2);
    localparam logic [CFG_AW-1:0] CFG_FIXED_R   = CFG_AW'(3);
    localparam logic [CFG_AW-1:0] CFG_THRESHOLD = CFG_AW'(4);

    localparam logic [MAXIT_W-1:0] RST_MAX_IT    = MAXIT_W'(12);
    localparam logic [SCALE_W-1:0] RST_SCALE     = SCALE_W'(163840);
    localparam logic [MINR_W-1:0]  RST_MIN_R     = MINR_W'(32768);
    localparam logic [FIXR_W-1:0]  RST_FIXED_R   = FIXR_W'(65536);
    localparam logic [DIST_W-1:0]  RST_THRESHOLD = DIST_W'(983);

    localparam logic [1:0] K_LAST_Z = 2'd2;
    localparam logic [1:0] K_DR     = 2'd3;

    typedef enum logic [2:0] {
        MOP_SQ  = 3'd0,
        MOP_ZF  = 3'd1,
        MOP_ZS  = 3'd2,
        MOP_DRF = 3'd3,
        MOP_DRS = 3'd4
    } t_mop;

    typedef enum logic [1:0] {
        DOP_FIN  = 2'd0,
        DOP_FOUT = 2'd1,
        DOP_DIST = 2'd2
    } t_dop;

    typedef struct packed {
        logic       load;
        logic       fold;
        logic       r2_clr;
        logic       f_sel_in;
        logic       it_inc;
        logic       mul_start;
        t_mop       mul_op;
        logic [1:0] k;
        logic       sqrt_start;
        logic       div_start;
        t_dop       div_op;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic sqrt_done;
        logic div_done;
        logic max_zero;
        logic inner;
        logic outer;
        logic root_zero;
        logic escape;
        logic last_it;
    } t_sts;

endpackage

// ----- src/mbde_mul.sv -----
// Multi-cycle unsigned multiplier, one digit of the second operand per cycle.
module mbde_mul
    import mbde_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic               o_done,
    output logic [MUL_P_W-1:0] o_prod
);

    localparam int CNT_W = $clog2(MUL_NDIG + 1);

    logic [MUL_A_W-1:0] r_a;
    logic [MUL_B_W-1:0] r_b;
    logic [MUL_P_W-1:0] r_acc;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_run;
    logic               r_done;
    logic [MUL_A_W+MUL_DIG-1:0] w_pp;

    assign w_pp = r_a * r_b[MUL_B_W-1 -: MUL_DIG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a   <= i_a;
                r_b   <= i_b;
                r_acc <= '0;
                r_cnt <= '0;
                r_run <= 1'b1;
            end else if (r_run) begin
                r_acc <= (r_acc << MUL_DIG) + MUL_P_W'(w_pp);
                r_b   <= r_b << MUL_DIG;
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MUL_NDIG - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ----- src/mbde_sqrt.sv -----
// Bit-serial floor square root, one root bit per cycle.
module mbde_sqrt
    import mbde_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [R2_W-1:0] i_v,
    output logic            o_done,
    output logic [SQ_W-1:0] o_root
);

    localparam int CNT_W = $clog2(SQ_W + 1);

    logic [R2_W-1:0] r_v;
    logic [SQ_W:0]   r_rem;
    logic [SQ_W-1:0] r_root;
    logic [CNT_W-1:0] r_cnt;
    logic            r_run;
    logic            r_done;
    logic [SQ_W+2:0] w_rem2;
    logic [SQ_W+2:0] w_trial;
    logic            w_ge;

    assign w_rem2  = {r_rem, r_v[R2_W-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_ge    = (w_rem2 >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_v    <= i_v;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_run  <= 1'b1;
            end else if (r_run) begin
                r_v    <= r_v << 2;
                r_rem  <= w_ge ? (SQ_W+1)'(w_rem2 - w_trial) : w_rem2[SQ_W:0];
                r_root <= {r_root[SQ_W-2:0], w_ge};
                r_cnt  <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SQ_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- src/mbde_div.sv -----
// Restoring divider, one quotient bit per cycle.
module mbde_div
    import mbde_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_num,
    input  logic [DIV_W-1:0] i_den,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_n;
    logic [DIV_W-1:0] r_d;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;
    logic [DIV_W:0]   w_rem2;
    logic             w_ge;

    assign w_rem2 = {r_rem, r_n[DIV_W-1]};
    assign w_ge   = (w_rem2 >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_n   <= i_num;
                r_d   <= i_den;
                r_rem <= '0;
                r_q   <= '0;
                r_cnt <= '0;
                r_run <= 1'b1;
            end else if (r_run) begin
                r_n   <= r_n << 1;
                r_rem <= w_ge ? DIV_W'(w_rem2 - {1'b0, r_d}) : w_rem2[DIV_W-1:0];
                r_q   <= {r_q[DIV_W-2:0], w_ge};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// ----- src/mbde_dp.sv -----
// Datapath: point, z, dr, radius and fold factor registers with shared arithmetic units.
module mbde_dp
    import mbde_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_AW-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic signed [IN_W-1:0] i_point_x,
    input  logic signed [IN_W-1:0] i_point_y,
    input  logic signed [IN_W-1:0] i_point_z,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic [DIST_W-1:0]  o_distance,
    output logic               o_hit
);

    localparam logic signed [Z_W:0] ONE_Z = (Z_W+1)'(1 << FRAC);
    localparam logic [MUL_P_W:0]    HALF  = (MUL_P_W+1)'(1 << (FRAC - 1));

    function automatic logic signed [Z_W-1:0] box_fold(input logic signed [Z_W-1:0] v);
        logic signed [Z_W:0] w;
        logic signed [Z_W:0] r;
        w = {v[Z_W-1], v};
        r = w;
        if (w > ONE_Z) begin
            r = (ONE_Z <<< 1) - w;
        end else if (w < -ONE_Z) begin
            r = -(ONE_Z <<< 1) - w;
        end
        return r[Z_W-1:0];
    endfunction

    logic [MAXIT_W-1:0] r_max_it;
    logic [SCALE_W-1:0] r_scale;
    logic [MINR_W-1:0]  r_min;
    logic [FIXR_W-1:0]  r_fixed;
    logic [DIST_W-1:0]  r_thresh;
    logic [2*MINR_W-1:0] r_min2;
    logic [2*FIXR_W-1:0] r_fix2;

    logic signed [IN_W-1:0] r_p [3];
    logic signed [Z_W-1:0]  r_z [3];
    logic [DR_W-1:0]    r_dr;
    logic [R2_W-1:0]    r_r2;
    logic [SQ_W-1:0]    r_root;
    logic [F_W-1:0]     r_f_in;
    logic [F_W-1:0]     r_f;
    logic [MAXIT_W-1:0] r_it;
    logic [DIST_W-1:0]  r_dist;
    logic               r_hit;

    logic signed [Z_W-1:0]  w_zsel;
    logic signed [IN_W-1:0] w_psel;
    logic [Z_W-1:0]     w_zmag;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic               w_mul_done;
    logic [MUL_P_W-1:0] w_prod;
    logic [MUL_P_W:0]   w_prnd;
    logic [RND_W-1:0]   w_rnd;
    logic [RND_W:0]     w_rnd1;
    logic [Z_W-1:0]     w_zm;
    logic signed [Z_W-1:0] w_zres;
    logic [DR_W-1:0]    w_dr_f;
    logic [DR_W-1:0]    w_dr_s;
    logic               w_sqrt_done;
    logic [SQ_W-1:0]    w_root;
    logic [DIV_W-1:0]   w_num;
    logic [DIV_W-1:0]   w_den;
    logic               w_div_done;
    logic [DIV_W-1:0]   w_quo;
    logic [DIST_W-1:0]  w_dist;
    logic [MAXIT_W:0]   w_it_next;

    always_comb begin
        case (i_cmd.k)
            2'd1:    begin w_zsel = r_z[1]; w_psel = r_p[1]; end
            2'd2:    begin w_zsel = r_z[2]; w_psel = r_p[2]; end
            default: begin w_zsel = r_z[0]; w_psel = r_p[0]; end
        endcase
    end

    assign w_zmag = w_zsel[Z_W-1] ? Z_W'(-w_zsel) : Z_W'(w_zsel);

    always_comb begin
        case (i_cmd.mul_op)
            MOP_SQ:  begin w_mul_a = MUL_A_W'(w_zmag); w_mul_b = MUL_B_W'(w_zmag);  end
            MOP_ZF:  begin w_mul_a = MUL_A_W'(w_zmag); w_mul_b = MUL_B_W'(r_f);     end
            MOP_ZS:  begin w_mul_a = MUL_A_W'(w_zmag); w_mul_b = MUL_B_W'(r_scale); end
            MOP_DRF: begin w_mul_a = r_dr;             w_mul_b = MUL_B_W'(r_f);     end
            MOP_DRS: begin w_mul_a = r_dr;             w_mul_b = MUL_B_W'(r_scale); end
            default: begin w_mul_a = '0;               w_mul_b = '0;                end
        endcase
    end

    mbde_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // round half away from zero on the magnitude, then restore sign
    assign w_prnd = {1'b0, w_prod} + HALF;
    assign w_rnd  = w_prnd[MUL_P_W:FRAC];
    assign w_rnd1 = {1'b0, w_rnd} + (RND_W+1)'(ONE_Q);
    assign w_zm   = w_rnd[Z_W-1:0];

    always_comb begin
        w_zres = w_zsel[Z_W-1] ? -$signed(w_zm) : $signed(w_zm);
        if (i_cmd.mul_op == MOP_ZS) begin
            w_zres = w_zres + Z_W'(w_psel);
        end
    end

    assign w_dr_f = (|w_rnd[RND_W-1:DR_W])  ? DR_MAX : w_rnd[DR_W-1:0];
    assign w_dr_s = (|w_rnd1[RND_W:DR_W])   ? DR_MAX : w_rnd1[DR_W-1:0];

    mbde_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_v     (r_r2),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    always_comb begin
        case (i_cmd.div_op)
            DOP_FIN: begin
                w_num = DIV_W'({r_fixed, {FRAC{1'b0}}});
                w_den = DIV_W'(r_min);
            end
            DOP_FOUT: begin
                w_num = DIV_W'({r_fixed, {FRAC{1'b0}}});
                w_den = DIV_W'(r_root);
            end
            DOP_DIST: begin
                w_num = DIV_W'({r_root, {FRAC{1'b0}}});
                w_den = r_dr;
            end
            default: begin
                w_num = '0;
                w_den = '0;
            end
        endcase
    end

    mbde_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_dist    = (|w_quo[DIV_W-1:DIST_W]) ? DIST_MAX : w_quo[DIST_W-1:0];
    assign w_it_next = {1'b0, r_it} + (MAXIT_W+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_it <= RST_MAX_IT;
            r_scale  <= RST_SCALE;
            r_min    <= RST_MIN_R;
            r_fixed  <= RST_FIXED_R;
            r_thresh <= RST_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MAX_IT:    r_max_it <= i_cfg_data[MAXIT_W-1:0];
                CFG_SCALE:     r_scale  <= i_cfg_data[SCALE_W-1:0];
                CFG_MIN_R:     r_min    <= i_cfg_data[MINR_W-1:0];
                CFG_FIXED_R:   r_fixed  <= i_cfg_data[FIXR_W-1:0];
                CFG_THRESHOLD: r_thresh <= i_cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_min2 <= r_min * r_min;
        r_fix2 <= r_fixed * r_fixed;

        if (i_cmd.load) begin
            r_p[0] <= i_point_x;
            r_p[1] <= i_point_y;
            r_p[2] <= i_point_z;
            r_z[0] <= Z_W'(i_point_x);
            r_z[1] <= Z_W'(i_point_y);
            r_z[2] <= Z_W'(i_point_z);
            r_dr   <= ONE_Q;
            r_it   <= '0;
        end
        if (i_cmd.fold) begin
            for (int i = 0; i < 3; i++) begin
                r_z[i] <= box_fold(r_z[i]);
            end
        end
        if (i_cmd.r2_clr) begin
            r_r2 <= '0;
        end
        if (i_cmd.it_inc) begin
            r_it <= w_it_next[MAXIT_W-1:0];
        end
        if (i_cmd.f_sel_in) begin
            r_f <= r_f_in;
        end
        if (w_mul_done) begin
            case (i_cmd.mul_op)
                MOP_SQ:  r_r2 <= r_r2 + w_prod[R2_W-1:0];
                MOP_ZF,
                MOP_ZS: begin
                    case (i_cmd.k)
                        2'd1:    r_z[1] <= w_zres;
                        2'd2:    r_z[2] <= w_zres;
                        default: r_z[0] <= w_zres;
                    endcase
                end
                MOP_DRF: r_dr <= w_dr_f;
                MOP_DRS: r_dr <= w_dr_s;
                default: ;
            endcase
        end
        if (w_sqrt_done) begin
            r_root <= w_root;
        end
        if (w_div_done) begin
            case (i_cmd.div_op)
                DOP_FIN:  r_f_in <= w_quo[F_W-1:0];
                DOP_FOUT: r_f    <= w_quo[F_W-1:0];
                DOP_DIST: begin
                    r_dist <= w_dist;
                    r_hit  <= (w_dist < r_thresh);
                end
                default: ;
            endcase
        end
    end

    assign o_sts.mul_done  = w_mul_done;
    assign o_sts.sqrt_done = w_sqrt_done;
    assign o_sts.div_done  = w_div_done;
    assign o_sts.max_zero  = (r_max_it == '0);
    assign o_sts.inner     = (r_r2 < R2_W'(r_min2));
    assign o_sts.outer     = (r_r2 < R2_W'(r_fix2));
    assign o_sts.root_zero = (r_root == '0);
    assign o_sts.escape    = (r_r2 > ESC_R2);
    assign o_sts.last_it   = (w_it_next == {1'b0, r_max_it});

    assign o_distance = r_dist;
    assign o_hit      = r_hit;

endmodule

// ----- src/mbde_ctrl.sv -----
// Controller: sequences fold, norm, ball fold, scale and final distance steps.
module mbde_ctrl
    import mbde_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy,
    output logic o_valid
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_FINV   = 12'b0000_0000_0010,
        S_FOLD   = 12'b0000_0000_0100,
        S_NORM   = 12'b0000_0000_1000,
        S_BRANCH = 12'b0000_0001_0000,
        S_SQRT   = 12'b0000_0010_0000,
        S_FDIV   = 12'b0000_0100_0000,
        S_FMUL   = 12'b0000_1000_0000,
        S_SMUL   = 12'b0001_0000_0000,
        S_ESC    = 12'b0010_0000_0000,
        S_RSQRT  = 12'b0100_0000_0000,
        S_RDIV   = 12'b1000_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        NP_FOLD  = 2'd0,
        NP_ESC   = 2'd1,
        NP_FINAL = 2'd2
    } t_nphase;

    t_state  r_state, n_state;
    t_nphase r_phase, n_phase;
    logic [1:0] r_k, n_k;
    logic    r_issued, n_issued;
    logic    r_valid, n_valid;

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_k      = r_k;
        n_issued = r_issued;
        n_valid  = 1'b0;
        o_cmd    = '0;
        o_cmd.k  = r_k;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_issued   = 1'b0;
                    n_state    = S_FINV;
                end
            end
            S_FINV: begin
                o_cmd.div_op    = DOP_FIN;
                o_cmd.div_start = !r_issued;
                n_issued        = 1'b1;
                if (i_sts.div_done) begin
                    n_issued = 1'b0;
                    if (i_sts.max_zero) begin
                        o_cmd.r2_clr = 1'b1;
                        n_k          = '0;
                        n_phase      = NP_FINAL;
                        n_state      = S_NORM;
                    end else begin
                        n_state = S_FOLD;
                    end
                end
            end
            S_FOLD: begin
                o_cmd.fold   = 1'b1;
                o_cmd.r2_clr = 1'b1;
                n_k          = '0;
                n_phase      = NP_FOLD;
                n_state      = S_NORM;
            end
            S_NORM: begin
                o_cmd.mul_op    = MOP_SQ;
                o_cmd.mul_start = !r_issued;
                n_issued        = 1'b1;
                if (i_sts.mul_done) begin
                    n_issued = 1'b0;
                    if (r_k == K_LAST_Z) begin
                        n_k = '0;
                        case (r_phase)
                            NP_FOLD: n_state = S_BRANCH;
                            NP_ESC:  n_state = S_ESC;
                            default: n_state = S_RSQRT;
                        endcase
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end
            end
            S_BRANCH: begin
                n_k = '0;
                if (i_sts.inner) begin
                    o_cmd.f_sel_in = 1'b1;
                    n_state        = S_FMUL;
                end else if (i_sts.outer) begin
                    n_state = S_SQRT;
                end else begin
                    n_state = S_SMUL;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_start = !r_issued;
                n_issued         = 1'b1;
                if (i_sts.sqrt_done) begin
                    n_issued = 1'b0;
                    n_state  = S_FDIV;
                end
            end
            S_FDIV: begin
                o_cmd.div_op = DOP_FOUT;
                if (!r_issued && i_sts.root_zero) begin
                    n_k     = '0;
                    n_state = S_SMUL;
                end else begin
                    o_cmd.div_start = !r_issued;
                    n_issued        = 1'b1;
                    if (i_sts.div_done) begin
                        n_issued = 1'b0;
                        n_k      = '0;
                        n_state  = S_FMUL;
                    end
                end
            end
            S_FMUL: begin
                o_cmd.mul_op    = (r_k == K_DR) ? MOP_DRF : MOP_ZF;
                o_cmd.mul_start = !r_issued;
                n_issued        = 1'b1;
                if (i_sts.mul_done) begin
                    n_issued = 1'b0;
                    n_k      = r_k + 2'd1;
                    if (r_k == K_DR) begin
                        n_state = S_SMUL;
                    end
                end
            end
            S_SMUL: begin
                o_cmd.mul_op    = (r_k == K_DR) ? MOP_DRS : MOP_ZS;
                o_cmd.mul_start = !r_issued;
                n_issued        = 1'b1;
                if (i_sts.mul_done) begin
                    n_issued = 1'b0;
                    n_k      = r_k + 2'd1;
                    if (r_k == K_DR) begin
                        o_cmd.r2_clr = 1'b1;
                        n_phase      = NP_ESC;
                        n_state      = S_NORM;
                    end
                end
            end
            S_ESC: begin
                o_cmd.it_inc = 1'b1;
                if (i_sts.escape || i_sts.last_it) begin
                    n_state = S_RSQRT;
                end else begin
                    n_state = S_FOLD;
                end
            end
            S_RSQRT: begin
                o_cmd.sqrt_start = !r_issued;
                n_issued         = 1'b1;
                if (i_sts.sqrt_done) begin
                    n_issued = 1'b0;
                    n_state  = S_RDIV;
                end
            end
            S_RDIV: begin
                o_cmd.div_op    = DOP_DIST;
                o_cmd.div_start = !r_issued;
                n_issued        = 1'b1;
                if (i_sts.div_done) begin
                    n_issued = 1'b0;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_issued = 1'b0;
                n_state  = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= NP_FOLD;
            r_k      <= '0;
            r_issued <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_k      <= n_k;
            r_issued <= n_issued;
            r_valid  <= n_valid;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

// ----- src/mandelbox_distance_estimate.sv -----
// The bit-serial square root and divider take 27 and 48 steps, and one 3-digit
// multiplier is shared by all products.
// One point is worked at a time; start is taken only while busy is low.
// The result shows for one cycle with o_valid, as busy falls; it cannot be held off.
// Reset is synchronous, active low; it idles the block and loads register defaults.
module mandelbox_distance_estimate
    import mbde_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic signed [IN_W-1:0] i_point_x,
    input  logic signed [IN_W-1:0] i_point_y,
    input  logic signed [IN_W-1:0] i_point_z,
    input  logic                   i_cfg_we,
    input  logic [CFG_AW-1:0]      i_cfg_addr,
    input  logic [CFG_W-1:0]       i_cfg_data,
    output logic                   o_valid,
    output logic [DIST_W-1:0]      o_distance,
    output logic                   o_hit
);

    t_cmd w_cmd;
    t_sts w_sts;

    mbde_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    mbde_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_point_x  (i_point_x),
        .i_point_y  (i_point_y),
        .i_point_z  (i_point_z),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_distance (o_distance),
        .o_hit      (o_hit)
    );

endmodule

// ----- src/mbde_checker.sv -----
// Port-level checks for the distance estimator, bound to the top level.
module mbde_checker
    import mbde_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input logic [DIST_W-1:0] o_distance
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while busy");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result beat longer than one cycle");

    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid && !$isunknown(o_distance))
        else $error("busy fell without a result beat");

endmodule

bind mandelbox_distance_estimate mbde_checker u_mbde_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_distance (o_distance)
);

// ----- verif/testbench.sv -----
// Self-checking testbench for the Mandelbox distance estimator: predicted distances vs DUT.
`timescale 1ns / 1ps

module testbench;
    import mbde_pkg::*;

    typedef enum logic [1:0] {JOB_POINT, JOB_CFG, JOB_DRAIN} t_job_kind;

    typedef struct {
        t_job_kind          kind;
        logic [CFG_AW-1:0]  addr;
        logic [CFG_W-1:0]   data;
        logic [IN_W-1:0]    x, y, z;
        int                 gap;
    } t_job;

    typedef struct {
        logic [DIST_W-1:0] dval;
        logic              hit;
    } t_estimate;

    localparam longint unsigned HALF_LSB = 64'd1 << (FRAC - 1);
    localparam longint unsigned ONE_FX   = 64'd1 << FRAC;
    localparam longint unsigned DR_SAT   = (64'd1 << (32 + FRAC)) - 1;
    localparam longint unsigned DIST_SAT = 64'd4194303;
    localparam longint unsigned ESCAPE   = 64'd100 << (2 * FRAC);

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic signed [IN_W-1:0] i_point_x = '0;
    logic signed [IN_W-1:0] i_point_y = '0;
    logic signed [IN_W-1:0] i_point_z = '0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]      i_cfg_addr = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   o_valid;
    logic [DIST_W-1:0]      o_distance;
    logic                   o_hit;

    mandelbox_distance_estimate dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [MAXIT_W-1:0] cf_iters  = RST_MAX_IT;
    logic [SCALE_W-1:0] cf_scale  = RST_SCALE;
    logic [MINR_W-1:0]  cf_minr   = RST_MIN_R;
    logic [FIXR_W-1:0]  cf_fixr   = RST_FIXED_R;
    logic [DIST_W-1:0]  cf_thresh = RST_THRESHOLD;

    t_job      jobs[$];
    t_estimate pending[$];
    t_job      cur;
    logic      have_cur = 1'b0;
    logic      took = 1'b0;
    int        gap_left = 0;
    int        errors = 0, n_points = 0, n_results = 0, n_hits = 0, n_cfg = 0;

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned mag(longint a);
        longint unsigned m;
        m = (a < 0) ? -a : a;
        return m;
    endfunction

    function automatic longint scale_signed(longint a, longint unsigned b);
        longint unsigned r;
        r = (mag(a) * b + HALF_LSB) >> FRAC;
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint unsigned scale_dr(longint unsigned a, longint unsigned b);
        longint unsigned r;
        if (a != 0 && b > (64'hFFFF_FFFF_FFFF_FFFF - HALF_LSB) / a) return DR_SAT;
        r = (a * b + HALF_LSB) >> FRAC;
        return (r > DR_SAT) ? DR_SAT : r;
    endfunction

    function automatic longint fold_box(longint v);
        if (v > longint'(ONE_FX)) return 2 * longint'(ONE_FX) - v;
        if (v < -longint'(ONE_FX)) return -2 * longint'(ONE_FX) - v;
        return v;
    endfunction

    function automatic longint unsigned sq_norm(longint a, longint b, longint c);
        return mag(a) * mag(a) + mag(b) * mag(b) + mag(c) * mag(c);
    endfunction

    function automatic t_estimate estimate_distance(logic signed [IN_W-1:0] px,
                                                    logic signed [IN_W-1:0] py,
                                                    logic signed [IN_W-1:0] pz);
        longint p[3], zv[3];
        longint unsigned dr, r2, root, f, dq, minr, fixr;
        t_estimate e;
        p[0] = px; p[1] = py; p[2] = pz;
        zv = p;
        dr = ONE_FX;
        minr = cf_minr;
        fixr = cf_fixr;
        for (int it = 0; it < int'(cf_iters); it++) begin
            for (int k = 0; k < 3; k++) zv[k] = fold_box(zv[k]);
            r2 = sq_norm(zv[0], zv[1], zv[2]);
            if (r2 < minr * minr) begin
                f = (minr != 0) ? (fixr << FRAC) / minr : 0;
                for (int k = 0; k < 3; k++) zv[k] = scale_signed(zv[k], f);
                dr = scale_dr(dr, f);
            end else if (r2 < fixr * fixr) begin
                root = isqrt(r2);
                if (root != 0) begin
                    f = (fixr << FRAC) / root;
                    for (int k = 0; k < 3; k++) zv[k] = scale_signed(zv[k], f);
                    dr = scale_dr(dr, f);
                end
            end
            for (int k = 0; k < 3; k++) zv[k] = scale_signed(zv[k], cf_scale) + p[k];
            dr = scale_dr(dr, cf_scale) + ONE_FX;
            if (dr > DR_SAT) dr = DR_SAT;
            if (sq_norm(zv[0], zv[1], zv[2]) > ESCAPE) break;
        end
        root = isqrt(sq_norm(zv[0], zv[1], zv[2]));
        dq = (dr != 0) ? (root << FRAC) / dr : DIST_SAT;
        if (dq > DIST_SAT) dq = DIST_SAT;
        e.dval = dq[DIST_W-1:0];
        e.hit  = (dq < longint'(cf_thresh));
        return e;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (start) begin
                if (took) begin
                    start <= 1'b0;
                    took <= 1'b0;
                end
            end else if (i_cfg_we) begin
                i_cfg_we <= 1'b0;
            end else if (!have_cur) begin
                if (jobs.size() != 0) begin
                    cur = jobs.pop_front();
                    have_cur <= 1'b1;
                    gap_left <= cur.gap;
                end
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else begin
                case (cur.kind)
                    JOB_POINT: begin
                        start <= 1'b1;
                        i_point_x <= cur.x;
                        i_point_y <= cur.y;
                        i_point_z <= cur.z;
                        have_cur <= 1'b0;
                    end
                    JOB_CFG: if (pending.size() == 0 && !busy) begin
                        i_cfg_we <= 1'b1;
                        i_cfg_addr <= cur.addr;
                        i_cfg_data <= cur.data;
                        have_cur <= 1'b0;
                    end
                    default: if (pending.size() == 0 && !busy) have_cur <= 1'b0;
                endcase
            end
        end
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                n_cfg++;
                case (i_cfg_addr)
                    CFG_MAX_IT:    cf_iters  <= i_cfg_data[MAXIT_W-1:0];
                    CFG_SCALE:     cf_scale  <= i_cfg_data[SCALE_W-1:0];
                    CFG_MIN_R:     cf_minr   <= i_cfg_data[MINR_W-1:0];
                    CFG_FIXED_R:   cf_fixr   <= i_cfg_data[FIXR_W-1:0];
                    CFG_THRESHOLD: cf_thresh <= i_cfg_data[DIST_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy && !took) begin
                pending.push_back(estimate_distance(i_point_x, i_point_y, i_point_z));
                took <= 1'b1;
                n_points++;
            end
            if (o_valid) begin
                n_results++;
                if (pending.size() == 0) begin
                    report($sformatf("unexpected beat dist=%0d hit=%0b", o_distance, o_hit));
                end else begin
                    t_estimate e;
                    e = pending.pop_front();
                    if (o_distance !== e.dval)
                        report($sformatf("distance %0d, want %0d", o_distance, e.dval));
                    if (o_hit !== e.hit)
                        report($sformatf("hit %0b, want %0b (dist %0d)", o_hit, e.hit, e.dval));
                    if (e.hit) n_hits++;
                end
            end
        end
    end

    task automatic add_point(input logic [IN_W-1:0] x, y, z, input int gap);
        t_job j;
        j.kind = JOB_POINT; j.x = x; j.y = y; j.z = z; j.gap = gap;
        j.addr = '0; j.data = '0;
        jobs.push_back(j);
    endtask

    task automatic add_cfg(input logic [CFG_AW-1:0] addr, input logic [CFG_W-1:0] data);
        t_job j;
        j.kind = JOB_CFG; j.addr = addr; j.data = data; j.gap = $urandom_range(0, 3);
        j.x = '0; j.y = '0; j.z = '0;
        jobs.push_back(j);
    endtask

    task automatic add_drain();
        t_job j;
        j.kind = JOB_DRAIN; j.gap = 0; j.addr = '0; j.data = '0;
        j.x = '0; j.y = '0; j.z = '0;
        jobs.push_back(j);
    endtask

    task automatic set_regs(input int it, sc, mn, fx, th);
        add_cfg(CFG_MAX_IT, it);
        add_cfg(CFG_SCALE, sc);
        add_cfg(CFG_MIN_R, mn);
        add_cfg(CFG_FIXED_R, fx);
        add_cfg(CFG_THRESHOLD, th);
    endtask

    function automatic logic [IN_W-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return IN_W'($urandom);
            1: return IN_W'(int'($urandom_range(0, 262144)) - 131072);
            2: return IN_W'(int'($urandom_range(0, 8192)) - 4096);
            default: return IN_W'(int'($urandom_range(0, 524288)) - 262144);
        endcase
    endfunction

    task automatic random_points(input int n);
        int mode, gap;
        mode = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) begin
            if (mode == 0) gap = 0;
            else if (mode == 1) gap = $urandom_range(0, 19);
            else gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
            add_point(rand_coord(), rand_coord(), rand_coord(), gap);
            if (i == n / 2 && $urandom_range(0, 1)) add_drain();
        end
    endtask

    initial begin
        logic [IN_W-1:0] dv[12];
        dv = '{20'h00000, 20'h7FFFF, 20'h80000, 20'h10000, 20'hF0000, 20'h10001,
               20'hEFFFF, 20'h00001, 20'hFFFFF, 20'h08000, 20'h20000, 20'h04000};
        // directed: reset settings
        for (int i = 0; i < 12; i++) add_point(dv[i], dv[(i + 3) % 12], dv[(i + 7) % 12], 0);
        add_point(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 2);
        add_point(20'h80000, 20'h80000, 20'h80000, 0);
        add_point(20'h00000, 20'h00000, 20'h00001, 5);
        add_drain();
        // zero iterations, zero scale, zero min radius
        set_regs(0, 163840, 32768, 65536, 50000);
        add_point(20'h00000, 20'h00000, 20'h00000, 0);
        add_point(20'h7FFFF, 20'h80000, 20'h10000, 0);
        set_regs(5, 0, 0, 65536, 1000);
        add_point(20'h00000, 20'h00000, 20'h00000, 0);
        add_point(20'h00001, 20'h00000, 20'h00000, 0);
        add_point(20'h08000, 20'hF8000, 20'h00100, 1);
        add_drain();

        set_regs(12, 163840, 32768, 65536, 983);
        random_points(170);
        set_regs(1, 65536, 1024, 32768, 0);
        random_points(140);
        set_regs(31, 262144, 65536, 131072, 4194303);
        random_points(40);
        set_regs(0, 163840, 32768, 65536, 50000);
        random_points(80);
        set_regs(5, 0, 0, 65536, 1000);
        random_points(100);
        // all-ones scale, radius and threshold registers; min radius below fixed radius
        set_regs(8, 20'h7FFFF, 17'h1FFFF, 18'h3FFFF, 22'h3FFFFF);
        random_points(80);
        for (int ph = 0; ph < 8; ph++) begin
            set_regs($urandom_range(1, 14), $urandom_range(65536, 262144),
                     $urandom_range(1024, 65536), $urandom_range(32768, 131072),
                     $urandom_range(0, 20000));
            random_points(120);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (jobs.size() != 0 || have_cur || start || i_cfg_we);
        do @(posedge i_clk); while (pending.size() != 0);
        repeat (200) @(posedge i_clk);
        if (pending.size() != 0) report($sformatf("%0d results never arrived", pending.size()));
        $display("Run: %0d points driven, %0d results checked (%0d hits), %0d register writes.",
                 n_points, n_results, n_hits, n_cfg);
        if (errors == 0) begin
            $display("** mandelbox_distance_estimate: PASSED **");
        end else begin
            $display("** mandelbox_distance_estimate: FAILED **");
        end
        $finish;
    end

    initial begin
        #300ms;
        $display("Timeout with %0d results outstanding.", pending.size());
        $display("** mandelbox_distance_estimate: FAILED **");
        $finish;
    end

endmodule
